### rtl/svf_pkg.sv
// ----------------------------------------------------------------------------
// svf_pkg
// Shared widths, defaults and arithmetic helpers of the state-variable filter.
// ----------------------------------------------------------------------------
package svf_pkg;

    localparam int unsigned LIMIT_DEPTH_DEF = 512;
    localparam int unsigned SAMPLE_W_DEF    = 24;

    localparam int unsigned ACC_W   = 32;   // state and internal high-pass
    localparam int unsigned COEF_W  = 18;   // cutoff and limits, unsigned Q2.16
    localparam int unsigned RES_W   = 16;   // resonance, signed Q1.14
    localparam int unsigned Q_W     = 14;   // clamped resonance
    localparam int unsigned DAMP_W  = 16;   // damping, unsigned Q2.14
    localparam int unsigned OP_W    = COEF_W + 1;      // signed multiplier operand
    localparam int unsigned PROD_W  = ACC_W + OP_W;    // full product
    localparam int unsigned SUM_W   = 40;   // headroom for sums before saturation

    localparam int unsigned COEF_SHIFT = 16;
    localparam int unsigned DAMP_SHIFT = 14;
    localparam int unsigned Q_FRAC     = 14;

    localparam logic [Q_W-1:0]    RESON_MAX = Q_W'(16371);
    localparam logic [COEF_W-1:0] COEF_MAX  = '1;
    localparam logic [DAMP_W-1:0] DAMP_ONE  = DAMP_W'(32768);

    // Stability limit: round(65536 * 0.1 * (0.000025 j^2 + 0.009 j + 7.8)), saturated.
    function automatic logic [COEF_W-1:0] limit_entry(input int unsigned j);
        longint unsigned poly;
        longint unsigned v;
        poly = 64'd25 * j * j + 64'd9000 * j + 64'd7800000;
        v    = (64'd65536 * poly + 64'd5000000) / 64'd10000000;
        if (v > 64'(COEF_MAX)) begin
            v = 64'(COEF_MAX);
        end
        return COEF_W'(v);
    endfunction

    // Round half up, then floor shift.
    function automatic logic signed [SUM_W-1:0] round_shr(
        input logic signed [PROD_W-1:0] prod,
        input int unsigned              sh
    );
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] shifted;
        biased  = prod + (PROD_W'(1) << (sh - 1));
        shifted = biased >>> sh;
        return shifted[SUM_W-1:0];
    endfunction

    // Saturate a sum to the accumulator width.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(ACC_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end
        return v[ACC_W-1:0];
    endfunction

endpackage

### rtl/state_variable_filter_core.sv
// ----------------------------------------------------------------------------
// state_variable_filter_core
// Two-pole state-variable filter: low, high, band and notch from one sample.
// ----------------------------------------------------------------------------
// A sample is accepted only in S_IDLE, after the last result has been loaded;
//   the single shared multiplier runs three dependent products per sample
//   (band*damp, band*f, high*f), and the result is registered in S_DONE.
// A result waiting on m_tready holds the sequencer in its last step.
// Reset (aresetn low, synchronous): clears filter state to zero, empties the
//   output register and returns the sequencer to idle.
module state_variable_filter_core #(
    parameter int unsigned LIMIT_TABLE_DEPTH = svf_pkg::LIMIT_DEPTH_DEF,
    parameter int unsigned SAMPLE_WIDTH      = svf_pkg::SAMPLE_W_DEF,
    localparam int unsigned IN_TDATA_W  =
        ((SAMPLE_WIDTH + svf_pkg::COEF_W + svf_pkg::RES_W + 7) / 8) * 8,
    localparam int unsigned OUT_TDATA_W = ((4 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // sample_in, cutoff_coef, resonance, zero padding
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // low_out, high_out, band_out, notch_out, zero padding
    output logic [OUT_TDATA_W-1:0]  m_tdata
);
    import svf_pkg::*;

    localparam int unsigned ADDR_W = $clog2(LIMIT_TABLE_DEPTH);
    localparam int unsigned IDX_W  = Q_W + ADDR_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LIMIT_TABLE_DEPTH - 1);
    localparam logic signed [ACC_W:0] OUT_MAX =
        (ACC_W + 1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ACC_W:0] OUT_MIN = -OUT_MAX - (ACC_W + 1)'(1);

    // Sequencer steps, one-hot.
    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,  // wait for a sample, issue the limit read
        S_LIMIT    = 7'b0000010,  // clamp cutoff, multiply band by damping
        S_LOW_MUL  = 7'b0000100,  // multiply band by cutoff
        S_LOW_ADD  = 7'b0001000,  // advance the low-pass state
        S_HIGH     = 7'b0010000,  // form the high-pass value
        S_BAND_MUL = 7'b0100000,  // multiply high by cutoff
        S_DONE     = 7'b1000000   // advance band-pass, load the result
    } seq_state_t;

    seq_state_t state_reg, state_next;

    // Payload of the sample in flight.
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [COEF_W-1:0]              f_reg;
    logic [Q_W-1:0]                 q_reg;
    logic [DAMP_W-1:0]              damp_reg;
    logic signed [SUM_W-1:0]        damp_term_reg;
    logic signed [ACC_W-1:0]        hp_reg;

    // Filter state.
    logic signed [ACC_W-1:0]        low_reg, low_next;
    logic signed [ACC_W-1:0]        band_reg, band_next;

    // Result register.
    logic                           out_valid_reg;
    logic [OUT_TDATA_W-1:0]         out_data_reg;

    // Input fields.
    logic signed [SAMPLE_WIDTH-1:0] in_sample;
    logic [COEF_W-1:0]              in_coef;
    logic signed [RES_W-1:0]        in_reson;
    logic [Q_W-1:0]                 q_clamp;
    logic [IDX_W-1:0]               idx_full;
    logic [ADDR_W-1:0]              rom_addr;
    logic [COEF_W-1:0]              rom_limit;

    // Shared multiplier.
    logic                           mul_en;
    logic signed [ACC_W-1:0]        mul_a;
    logic signed [OP_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]       mul_prod;

    logic                           in_xfer;
    logic                           out_free;
    logic signed [SUM_W-1:0]        hp_sum;
    logic signed [ACC_W:0]          notch_sum;
    logic signed [SAMPLE_WIDTH-1:0] low_o, high_o, band_o, notch_o;

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_out(
        input logic signed [ACC_W:0] v
    );
        logic signed [ACC_W:0] r;
        if (v > OUT_MAX) begin
            r = OUT_MAX;
        end else if (v < OUT_MIN) begin
            r = OUT_MIN;
        end else begin
            r = v;
        end
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Input decode: clamp resonance and form the table index.
    // ------------------------------------------------------------------
    assign in_sample = s_tdata[SAMPLE_WIDTH-1:0];
    assign in_coef   = s_tdata[SAMPLE_WIDTH +: COEF_W];
    assign in_reson  = s_tdata[SAMPLE_WIDTH + COEF_W +: RES_W];

    always_comb begin
        if (in_reson[RES_W-1]) begin
            q_clamp = '0;
        end else if (in_reson[RES_W-2:0] > (RES_W - 1)'(RESON_MAX)) begin
            q_clamp = RESON_MAX;
        end else begin
            q_clamp = in_reson[Q_W-1:0];
        end
    end

    // floor(q * depth / 2^14), held inside the table.
    assign idx_full = IDX_W'((IDX_W'(q_clamp) * IDX_W'(LIMIT_TABLE_DEPTH)) >> Q_FRAC);
    assign rom_addr = (idx_full > IDX_LAST) ? IDX_LAST[ADDR_W-1:0] : idx_full[ADDR_W-1:0];

    svf_limit_rom #(
        .DEPTH  (LIMIT_TABLE_DEPTH)
    ) u_limit_rom (
        .aclk    (aclk),
        .addr    (rom_addr),
        .rd_data (rom_limit)
    );

    // ------------------------------------------------------------------
    // Shared multiplier: operands steered by the sequencer step.
    // ------------------------------------------------------------------
    assign mul_en = (state_reg == S_LIMIT) || (state_reg == S_LOW_MUL)
                 || (state_reg == S_BAND_MUL);
    assign mul_a  = (state_reg == S_BAND_MUL) ? hp_reg : band_reg;
    assign mul_b  = (state_reg == S_LIMIT) ? OP_W'(damp_reg) : OP_W'(f_reg);

    svf_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    // ------------------------------------------------------------------
    // Datapath sums.
    // ------------------------------------------------------------------
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign low_next  = sat_acc(SUM_W'(low_reg) + round_shr(mul_prod, COEF_SHIFT));
    assign hp_sum    = SUM_W'(x_reg) - damp_term_reg - SUM_W'(low_reg);
    assign band_next = sat_acc(SUM_W'(band_reg) + round_shr(mul_prod, COEF_SHIFT));
    assign notch_sum = (ACC_W + 1)'(hp_reg) + (ACC_W + 1)'(low_reg);

    assign low_o   = sat_out((ACC_W + 1)'(low_reg));
    assign high_o  = sat_out((ACC_W + 1)'(hp_reg));
    assign band_o  = sat_out((ACC_W + 1)'(band_next));
    assign notch_o = sat_out(notch_sum);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (s_tvalid) state_next = S_LIMIT;
            S_LIMIT:    state_next = S_LOW_MUL;
            S_LOW_MUL:  state_next = S_LOW_ADD;
            S_LOW_ADD:  state_next = S_HIGH;
            S_HIGH:     state_next = S_BAND_MUL;
            S_BAND_MUL: state_next = S_DONE;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            band_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_LOW_ADD) begin
                low_reg <= low_next;
            end
            // Advance band state only on the cycle the result is loaded.
            if (state_reg == S_DONE && out_free) begin
                band_reg      <= band_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg    <= in_sample;
            f_reg    <= in_coef;
            q_reg    <= q_clamp;
            damp_reg <= DAMP_ONE - DAMP_W'({q_clamp, 1'b0});
        end
        if (state_reg == S_LIMIT && f_reg > rom_limit) begin
            f_reg <= rom_limit;
        end
        if (state_reg == S_LOW_MUL) begin
            damp_term_reg <= round_shr(mul_prod, DAMP_SHIFT);
        end
        if (state_reg == S_HIGH) begin
            hp_reg <= sat_acc(hp_sum);
        end
        if (state_reg == S_DONE && out_free) begin
            out_data_reg <= OUT_TDATA_W'({notch_o, band_o, high_o, low_o});
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == S_LIMIT)
        else $error("accepted sample did not start the sequence");

    a_cutoff_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LIMIT |=> f_reg <= $past(rom_limit))
        else $error("cutoff not clamped to the stability limit");

    a_reson_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_LOW_MUL |-> q_reg <= RESON_MAX)
        else $error("resonance outside clamp range");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("finished sample not loaded into the result register");

endmodule

### rtl/svf_limit_rom.sv
// ----------------------------------------------------------------------------
// svf_limit_rom
// Stability limit table, contents fixed at elaboration, registered read.
// ----------------------------------------------------------------------------
module svf_limit_rom #(
    parameter int unsigned DEPTH = svf_pkg::LIMIT_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic [$clog2(DEPTH)-1:0]         addr,
    output logic [svf_pkg::COEF_W-1:0]       rd_data
);
    import svf_pkg::*;

    logic [COEF_W-1:0] rom_array [DEPTH];
    logic [COEF_W-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_entry
        localparam logic [COEF_W-1:0] ENTRY = limit_entry(i);
        assign rom_array[i] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= rom_array[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/svf_mul.sv
// ----------------------------------------------------------------------------
// svf_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module svf_mul (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [svf_pkg::ACC_W-1:0]     op_a,
    input  logic signed [svf_pkg::OP_W-1:0]      op_b,
    output logic signed [svf_pkg::PROD_W-1:0]    prod
);
    import svf_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

### test/state_variable_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// state_variable_filter_core_tb
// Self-checking bench for the two-pole state-variable filter core.
// A directed table covers the field extremes, the resonance and cutoff clamps,
// and the pass-through from reset. Random segments follow: noise, held
// settings, extreme values, and square waves at the resonant frequency that
// push the accumulators into saturation. Every result is compared field by
// field with an in-bench fixed-point model of the filter.
// ----------------------------------------------------------------------------
module state_variable_filter_core_tb;

    localparam int S_W         = svf_pkg::SAMPLE_W_DEF;
    localparam int LIMIT_DEPTH = svf_pkg::LIMIT_DEPTH_DEF;
    localparam int COEF_W      = svf_pkg::COEF_W;
    localparam int RES_W       = svf_pkg::RES_W;
    localparam int ACC_W       = svf_pkg::ACC_W;
    localparam int IN_W        = ((S_W + COEF_W + RES_W + 7) / 8) * 8;
    localparam int OUT_W       = ((4 * S_W + 7) / 8) * 8;

    localparam longint Q_TOP      = 16371;        // resonance ceiling, 0.9992 in Q1.14
    localparam longint DAMP_UNITY = 32768;        // 2.0 in Q2.14
    localparam longint COEF_TOP   = 262143;
    localparam longint UNITY_COEF = 65536;        // 1.0 in Q2.16
    localparam longint SQRT2_COEF = 92682;        // sqrt(2): resonance at a quarter of fs
    localparam int     RANDOM_ITEMS = 1150;
    localparam int     IDLE_PCT     = 31;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef logic signed [S_W-1:0]   tap_t;
    typedef logic [COEF_W-1:0]       coef_t;
    typedef logic signed [RES_W-1:0] reson_t;
    typedef logic [4*S_W-1:0]        taps_t;   // notch, band, high, low from MSB down

    typedef struct packed {
        tap_t   sample;
        coef_t  cutoff;
        reson_t reson;
        logic   typed;      // use the literal below instead of the model
        taps_t  want;       // {notch, band, high, low}
    } stim_row_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata  = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    // Filter state of the model, ROM image and bookkeeping.
    longint low_state  = 0;
    longint band_state = 0;
    longint limit_rom [LIMIT_DEPTH];
    taps_t  taps_due [$];
    bit     calm = 1'b0;
    int     n_err = 0;
    int     n_sent = 0;
    int     n_got = 0;
    int     n_cycles = 0;
    int     n_f_clamped = 0;
    int     n_q_clamped = 0;
    int     n_acc_sat = 0;

    string tap_name [4] = '{"low_out", "high_out", "band_out", "notch_out"};

    // Directed table. From reset with a zero cutoff the state stays at zero, so
    // the input passes straight to high and notch: those rows are typed in.
    stim_row_t stim_tab [22] = '{
        '{24'h7FFFFF, 18'h00000, 16'h0000, 1'b1, {24'h7FFFFF, 24'h0, 24'h7FFFFF, 24'h0}},
        '{24'h800000, 18'h00000, 16'h8000, 1'b1, {24'h800000, 24'h0, 24'h800000, 24'h0}},
        '{24'h000000, 18'h00000, 16'h7FFF, 1'b1, {24'h000000, 24'h0, 24'h000000, 24'h0}},
        '{24'hFFFFFF, 18'h00000, 16'h3FF3, 1'b1, {24'hFFFFFF, 24'h0, 24'hFFFFFF, 24'h0}},
        '{24'h555555, 18'h00000, 16'h3FF4, 1'b1, {24'h555555, 24'h0, 24'h555555, 24'h0}},
        '{24'hAAAAAA, 18'h00000, 16'h4000, 1'b1, {24'hAAAAAA, 24'h0, 24'hAAAAAA, 24'h0}},
        '{24'h7FFFFF, 18'h3FFFF, 16'h0000, 1'b0, '0},
        '{24'h7FFFFF, 18'h3FFFF, 16'h3FF3, 1'b0, '0},
        '{24'h800000, 18'h3FFFF, 16'h7FFF, 1'b0, '0},
        '{24'h800000, 18'h00001, 16'h8000, 1'b0, '0},
        '{24'h7FFFFF, 18'h10000, 16'h3FFF, 1'b0, '0},
        '{24'h800000, 18'h10000, 16'h3FF3, 1'b0, '0},
        '{24'h7FFFFF, 18'h0C7AE, 16'h0000, 1'b0, '0},   // exactly at the q=0 limit
        '{24'h800000, 18'h0C7AF, 16'h0000, 1'b0, '0},   // one above it
        '{24'h400000, 18'h08000, 16'h2000, 1'b0, '0},
        '{24'hC00000, 18'h08000, 16'h2000, 1'b0, '0},
        '{24'h7FFFFF, 18'h3FFFF, 16'h3FF3, 1'b0, '0},
        '{24'h800000, 18'h3FFFF, 16'h3FF3, 1'b0, '0},
        '{24'h7FFFFF, 18'h3FFFF, 16'h3FF3, 1'b0, '0},
        '{24'h800000, 18'h3FFFF, 16'h3FF3, 1'b0, '0},
        '{24'h000001, 18'h00001, 16'h0001, 1'b0, '0},
        '{24'h7FFFFF, 18'h00000, 16'h3FF3, 1'b0, '0}
    };

    state_variable_filter_core #(
        .LIMIT_TABLE_DEPTH (LIMIT_DEPTH),
        .SAMPLE_WIDTH      (S_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Round half up: bias by half an LSB, then floor shift.
    function automatic longint round_shift(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input int w);
        longint top;
        top = (longint'(1) <<< (w - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    function automatic longint acc_clip(input longint v);
        if (clip(v, ACC_W) != v) n_acc_sat++;
        return clip(v, ACC_W);
    endfunction

    // Advance the model filter by one sample and return the four taps.
    function automatic taps_t filter_step(input tap_t smp, input coef_t cf, input reson_t rs);
        longint x, f, q, damp, hp, row;
        x = smp;
        f = cf;
        q = rs;
        if (q < 0) begin
            q = 0;
            n_q_clamped++;
        end else if (q > Q_TOP) begin
            q = Q_TOP;
            n_q_clamped++;
        end
        damp = DAMP_UNITY - 2 * q;
        row  = (q * LIMIT_DEPTH) >>> 14;
        if (row > LIMIT_DEPTH - 1) row = LIMIT_DEPTH - 1;
        if (f > limit_rom[row]) begin
            f = limit_rom[row];
            n_f_clamped++;
        end
        low_state  = acc_clip(low_state + round_shift(band_state * f, 16));
        hp         = acc_clip(x - round_shift(band_state * damp, 14) - low_state);
        band_state = acc_clip(band_state + round_shift(hp * f, 16));
        return {S_W'(clip(hp + low_state, S_W)), S_W'(clip(band_state, S_W)),
                S_W'(clip(hp, S_W)), S_W'(clip(low_state, S_W))};
    endfunction

    // Offer one sample, hold it until the transfer, then queue its taps.
    task automatic send_sample(input tap_t smp, input coef_t cf, input reson_t rs,
                               input bit typed, input taps_t want);
        taps_t pred;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({rs, cf, smp});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = filter_step(smp, cf, rs);
        taps_due.push_back(typed ? want : pred);
        n_sent++;
    endtask

    // Result side: stall at random, except during the calm stretch.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare every result transfer with the oldest queued taps.
    always @(posedge aclk) begin : check_taps
        taps_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_got++;
            if (taps_due.size() == 0) begin
                $display("%0t: unexpected result transfer, got %h", $time, m_tdata);
                n_err++;
            end else begin
                want = taps_due.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (m_tdata[k*S_W +: S_W] !== want[k*S_W +: S_W]) begin
                        $display("%0t: %s mismatch, expected %0d, got %0d", $time,
                                 tap_name[k], $signed(want[k*S_W +: S_W]),
                                 $signed(m_tdata[k*S_W +: S_W]));
                        n_err++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time, taps_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        longint poly;
        int     n_random;
        int     seg_kind;
        int     seg_len;
        int     sh;
        bit     first;
        tap_t   smp;
        coef_t  cf;
        reson_t rs;

        // Stability limits: 65536 * 0.1 * (0.000025 j^2 + 0.009 j + 7.8), rounded.
        for (int j = 0; j < LIMIT_DEPTH; j++) begin
            poly = 25 * longint'(j) * j + 9000 * longint'(j) + 7800000;
            limit_rom[j] = (65536 * poly + 5000000) / 10000000;
            if (limit_rom[j] > COEF_TOP) limit_rom[j] = COEF_TOP;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_tab[i]) begin
            send_sample(stim_tab[i].sample, stim_tab[i].cutoff, stim_tab[i].reson,
                        stim_tab[i].typed, stim_tab[i].want);
        end

        n_random = 0;
        first    = 1'b1;
        while (n_random < RANDOM_ITEMS) begin
            // Open with a long resonant drive so the accumulators reach their rails.
            seg_kind = first ? 6 : $urandom_range(9);
            sh       = $urandom_range(8);
            cf       = coef_t'($urandom_range(0, 18'h20000));
            rs       = $urandom_range(1) ? reson_t'($urandom_range(12000, 16383))
                                         : reson_t'($urandom);
            case (seg_kind)
                6, 7: begin
                    seg_len = first ? 500 : $urandom_range(100, 300);
                    cf      = first ? coef_t'(SQRT2_COEF)
                                    : ($urandom_range(1) ? coef_t'(SQRT2_COEF)
                                                         : coef_t'(UNITY_COEF));
                    rs      = first ? reson_t'(Q_TOP) : reson_t'($urandom_range(16200, 16383));
                end
                8, 9:    seg_len = $urandom_range(5, 20);
                default: seg_len = $urandom_range(10, 80);
            endcase
            for (int k = 0; k < seg_len && n_random < RANDOM_ITEMS; k++) begin
                calm <= (n_random >= 150 && n_random < 350);
                case (seg_kind)
                    0, 1, 2: begin
                        smp = tap_t'($urandom);
                        cf  = coef_t'($urandom);
                        rs  = reson_t'($urandom);
                    end
                    3, 4, 5: smp = tap_t'($urandom) >>> sh;
                    6, 7: begin
                        // Square wave at the resonance: period 4 for sqrt(2), 6 for unity.
                        if (cf == coef_t'(SQRT2_COEF))
                            smp = ((k / 2) % 2) ? tap_t'(24'h800000) : tap_t'(24'h7FFFFF);
                        else
                            smp = ((k / 3) % 2) ? tap_t'(24'h800000) : tap_t'(24'h7FFFFF);
                    end
                    default: begin
                        case ($urandom_range(4))
                            0:       smp = tap_t'(24'h7FFFFF);
                            1:       smp = tap_t'(24'h800000);
                            2:       smp = '0;
                            3:       smp = tap_t'(1);
                            default: smp = tap_t'(-1);
                        endcase
                        case ($urandom_range(3))
                            0:       cf = '0;
                            1:       cf = coef_t'(1);
                            2:       cf = coef_t'(COEF_TOP);
                            default: cf = coef_t'(limit_rom[$urandom_range(LIMIT_DEPTH - 1)]
                                                  + $urandom_range(1));
                        endcase
                        case ($urandom_range(4))
                            0:       rs = reson_t'(16'h8000);
                            1:       rs = reson_t'(16'h7FFF);
                            2:       rs = '0;
                            3:       rs = reson_t'(Q_TOP);
                            default: rs = reson_t'(Q_TOP + 1);
                        endcase
                    end
                endcase
                send_sample(smp, cf, rs, 1'b0, '0);
                n_random++;
            end
            first = 1'b0;
        end

        s_tvalid <= 1'b0;
        calm     <= 1'b0;
        while (taps_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Filtered %0d samples (%0d from the directed table), checked %0d results.",
                 n_sent, $size(stim_tab), n_got);
        $display("Cutoff clamped %0d times, resonance clamped %0d, accumulators saturated %0d.",
                 n_f_clamped, n_q_clamped, n_acc_sat);
        if (n_err == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/svf_pkg.sv
rtl/svf_limit_rom.sv
rtl/svf_mul.sv
rtl/state_variable_filter_core.sv
test/state_variable_filter_core_tb.sv
